### hdl/ssq_pkg.sv
// ============================================================================
// ssq_pkg: shared types for the sortable search queue
// Item layouts, operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ============================================================================
package ssq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        MD_PUSH   = 3'd0,
        MD_POP    = 3'd1,
        MD_SEARCH = 3'd2,
        MD_SORT   = 3'd3,
        MD_REV    = 3'd4,
        MD_DUMP   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]                 mode;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value_res;
        logic                       last;
        logic [COUNT_W-1:0]         count;
    } out_item_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_POP,
        CS_SRCH,
        CS_SRT_A,
        CS_SRT_CMP,
        CS_SRT_END,
        CS_REV_RDH,
        CS_REV_W1,
        CS_REV_W2,
        CS_RESP,
        CS_DUMP
    } ctrl_state_t;

    // Read address choice: the head, or an offset from the head.
    typedef enum logic [1:0] {
        RA_HEAD,
        RA_IDX1,
        RA_IDX2,
        RA_HI
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_TAIL,
        WA_IDX,
        WA_HI
    } wr_sel_t;

    typedef enum logic [1:0] {
        WD_IN,
        WD_RD,
        WD_A,
        WD_MIN
    } wd_sel_t;

    typedef enum logic [1:0] {
        A_HOLD,
        A_RD,
        A_MAX
    } a_sel_t;

    typedef enum logic {
        OV_ZERO,
        OV_RD
    } ov_sel_t;

    typedef struct packed {
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        wd_sel_t  wd_sel;
        a_sel_t   a_sel;
        logic     key_load;
        logic     idx_clr;
        logic     idx_inc;
        logic     hi_init;
        logic     hi_dec;
        logic     lim_init;
        logic     lim_dec;
        logic     swp_clr;
        logic     push;
        logic     pop;
        logic     out_load;
        status_t  out_status;
        ov_sel_t  out_val_sel;
        logic     out_last;
    } ssq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic lt2;
        logic hit;
        logic idx_last;
        logic srt_more;
        logic rev_more;
        logic lim_gt1;
        logic swapped;
    } ssq_stat_t;

endpackage

### hdl/ssq_ram.sv
// ============================================================================
// ssq_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is enabled.
// ============================================================================
module ssq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/ssq_ctrl.sv
// ============================================================================
// ssq_ctrl: operation sequencer
// Decodes each accepted item and steps the datapath through push, pop,
// search, sort, reverse and dump.
// ============================================================================
module ssq_ctrl
    import ssq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_mode,
    output logic       s_ready,
    input  ssq_stat_t  stat,
    output ssq_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        cmd              = '0;
        cmd.out_status   = ST_OK;
        cmd.out_val_sel  = OV_ZERO;
        cmd.out_last     = 1'b1;
        case (state_reg)
            CS_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    case (mode_t'(s_mode))
                        MD_PUSH: begin
                            cmd.out_load = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WA_TAIL;
                                cmd.wd_sel = WD_IN;
                                cmd.push   = 1'b1;
                            end
                        end
                        MD_POP: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RA_HEAD;
                                state_next = CS_POP;
                            end
                        end
                        MD_SEARCH: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_NOTFOUND;
                            end else begin
                                cmd.key_load = 1'b1;
                                cmd.idx_clr  = 1'b1;
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RA_HEAD;
                                state_next   = CS_SRCH;
                            end
                        end
                        MD_SORT: begin
                            if (stat.lt2) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.lim_init = 1'b1;
                                cmd.idx_clr  = 1'b1;
                                cmd.swp_clr  = 1'b1;
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RA_HEAD;
                                state_next   = CS_SRT_A;
                            end
                        end
                        MD_REV: begin
                            if (stat.lt2) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                cmd.hi_init = 1'b1;
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = RA_HEAD;
                                state_next  = CS_REV_RDH;
                            end
                        end
                        MD_DUMP: begin
                            if (stat.empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = RA_HEAD;
                                state_next  = CS_DUMP;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            CS_POP: begin
                if (stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_val_sel = OV_RD;
                    cmd.pop         = 1'b1;
                    state_next      = CS_IDLE;
                end
            end
            CS_SRCH: begin
                if (stat.hit) begin
                    if (stat.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_FOUND;
                        state_next     = CS_IDLE;
                    end
                end else if (stat.idx_last) begin
                    if (stat.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NOTFOUND;
                        state_next     = CS_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RA_IDX1;
                end
            end
            CS_SRT_A: begin
                cmd.a_sel  = A_RD;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_IDX1;
                state_next = CS_SRT_CMP;
            end
            CS_SRT_CMP: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WA_IDX;
                cmd.wd_sel  = WD_MIN;
                cmd.a_sel   = A_MAX;
                cmd.idx_inc = 1'b1;
                if (stat.srt_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX2;
                end else begin
                    state_next = CS_SRT_END;
                end
            end
            CS_SRT_END: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX;
                cmd.wd_sel = WD_A;
                if (stat.swapped && stat.lim_gt1) begin
                    cmd.lim_dec = 1'b1;
                    cmd.idx_clr = 1'b1;
                    cmd.swp_clr = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RA_HEAD;
                    state_next  = CS_SRT_A;
                end else begin
                    state_next = CS_RESP;
                end
            end
            CS_REV_RDH: begin
                cmd.a_sel  = A_RD;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_HI;
                state_next = CS_REV_W1;
            end
            CS_REV_W1: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX;
                cmd.wd_sel = WD_RD;
                state_next = CS_REV_W2;
            end
            CS_REV_W2: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WA_HI;
                cmd.wd_sel  = WD_A;
                cmd.idx_inc = 1'b1;
                cmd.hi_dec  = 1'b1;
                if (stat.rev_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX1;
                    state_next = CS_REV_RDH;
                end else begin
                    state_next = CS_RESP;
                end
            end
            CS_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            CS_DUMP: begin
                if (stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.out_val_sel = OV_RD;
                    cmd.out_last    = stat.idx_last;
                    if (stat.idx_last) begin
                        state_next = CS_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RA_IDX1;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

### hdl/ssq_dp.sv
// ============================================================================
// ssq_dp: queue datapath
// Ring pointers, element RAM, walk indices, compare logic and the result
// register with its valid flag.
// ============================================================================
module ssq_dp
    import ssq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_item,
    input  ssq_cmd_t   cmd,
    output ssq_stat_t  stat,
    input  logic       m_ready,
    output logic       m_valid,
    output out_item_t  m_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [IW-1:0]              head_reg, head_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [IW-1:0]              hi_reg, hi_next;
    logic [IW-1:0]              lim_reg, lim_next;
    logic signed [VALUE_W-1:0]  a_reg, a_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic                       swapped_reg, swapped_next;
    logic                       m_valid_reg, m_valid_next;
    out_item_t                  out_item_reg, out_item_next;

    logic [IW-1:0]              rd_addr, wr_addr;
    logic signed [VALUE_W-1:0]  wr_data, rd_data;
    logic                       less;
    logic                       out_free;

    // Ring position of an offset from the head.
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                           input logic [IW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= (IW+1)'(DEPTH)) begin
            s = s - (IW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign less     = rd_data < a_reg;

    always_comb begin
        case (cmd.rd_sel)
            RA_HEAD: rd_addr = head_reg;
            RA_IDX1: rd_addr = slot(head_reg, idx_reg + IW'(1));
            RA_IDX2: rd_addr = slot(head_reg, idx_reg + IW'(2));
            RA_HI:   rd_addr = slot(head_reg, hi_reg);
            default: rd_addr = head_reg;
        endcase
        case (cmd.wr_sel)
            WA_TAIL: wr_addr = slot(head_reg, count_reg[IW-1:0]);
            WA_IDX:  wr_addr = slot(head_reg, idx_reg);
            WA_HI:   wr_addr = slot(head_reg, hi_reg);
            default: wr_addr = head_reg;
        endcase
        case (cmd.wd_sel)
            WD_IN:   wr_data = s_item.value;
            WD_RD:   wr_data = rd_data;
            WD_A:    wr_data = a_reg;
            WD_MIN:  wr_data = less ? rd_data : a_reg;
            default: wr_data = s_item.value;
        endcase
    end

    ssq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        hi_next       = hi_reg;
        lim_next      = lim_reg;
        a_next        = a_reg;
        key_next      = key_reg;
        swapped_next  = swapped_reg;
        m_valid_next  = m_valid_reg;
        out_item_next = out_item_reg;

        if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            head_next  = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
        end

        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IW'(1);
        end

        if (cmd.hi_init) begin
            hi_next = IW'(count_reg - CW'(1));
        end else if (cmd.hi_dec) begin
            hi_next = hi_reg - IW'(1);
        end

        if (cmd.lim_init) begin
            lim_next = IW'(count_reg - CW'(1));
        end else if (cmd.lim_dec) begin
            lim_next = lim_reg - IW'(1);
        end

        case (cmd.a_sel)
            A_HOLD:  a_next = a_reg;
            A_RD:    a_next = rd_data;
            A_MAX:   a_next = less ? a_reg : rd_data;
            default: a_next = a_reg;
        endcase

        if (cmd.key_load) begin
            key_next = s_item.value;
        end

        if (cmd.swp_clr) begin
            swapped_next = 1'b0;
        end else if (cmd.a_sel == A_MAX && less) begin
            swapped_next = 1'b1;
        end

        if (cmd.out_load) begin
            m_valid_next            = 1'b1;
            out_item_next.status    = cmd.out_status;
            out_item_next.value_res = (cmd.out_val_sel == OV_RD) ? rd_data : '0;
            out_item_next.last      = cmd.out_last;
            out_item_next.count     = COUNT_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        hi_reg       <= hi_next;
        lim_reg      <= lim_next;
        a_reg        <= a_next;
        key_reg      <= key_next;
        swapped_reg  <= swapped_next;
        out_item_reg <= out_item_next;
    end

    always_comb begin
        stat.out_free = out_free;
        stat.empty    = count_reg == '0;
        stat.full     = count_reg == CW'(DEPTH);
        stat.lt2      = count_reg < CW'(2);
        stat.hit      = rd_data == key_reg;
        stat.idx_last = (CW'(idx_reg) + CW'(1)) == count_reg;
        stat.srt_more = ((IW+1)'(idx_reg) + (IW+1)'(1)) < (IW+1)'(lim_reg);
        stat.rev_more = ((IW+1)'(idx_reg) + (IW+1)'(2)) < (IW+1)'(hi_reg);
        stat.lim_gt1  = lim_reg > IW'(1);
        stat.swapped  = swapped_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_item_reg;

    // A new result must never overwrite one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten while stalled");

    // Sort and reverse steps always touch two different entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write collide on one entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (count_reg < CW'(DEPTH)))
        else $error("push into a full store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not drop the count by one");

endmodule

### hdl/sortable_search_queue.sv
// ============================================================================
// sortable_search_queue: bounded FIFO with search, sort, reverse and dump
// Ring store of signed 32-bit elements driven by a sequencer; each item
// carries one operation and yields one result, or one per element on dump.
// ============================================================================
//
//   Channel | Ports                       | Moves
//   --------+-----------------------------+----------------------------------
//   input   | s_valid, s_ready, s_item    | mode and value of one operation
//   result  | m_valid, m_ready, m_item    | status, value_res, last, count
//
// Push, and any item whose result is known at once, answers straight from idle;
// pop reads the head first. Search and dump walk up to the n queued elements,
// reverse swaps pairs from both ends, and sort makes compare passes, each one
// shorter than the last, with an early stop after a pass without a swap.
// Reset clears head, count and the result valid flag; the RAM keeps its data.
// A stalled result holds the sequencer; no item is accepted until one ends.
//
module sortable_search_queue
    import ssq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    // Commands from the sequencer to the datapath, and the datapath's flags
    // back to the sequencer.
    ssq_cmd_t  cmd;
    ssq_stat_t stat;

    // The sequencer decodes the item's mode and walks the operation.
    ssq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_item.mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath owns the ring store, the pointers and the result register.
    ssq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule
